>>> design/amfp_pkg.sv
package amfp_pkg;

	localparam int MaxLine = 64;
	localparam int CntW = $clog2(MaxLine + 1);
	localparam logic [30:0] VMax = 31'h7FFFFFFF;

	typedef enum logic [3:0] {
		ST_OK = 4'd0, ST_NOISE = 4'd1, ST_BAD_TYPE = 4'd2, ST_BAD_BRACE = 4'd3,
		ST_BAD_ATTR = 4'd4, ST_NO_SPACE = 4'd5, ST_BAD_NUM = 4'd6, ST_NO_COMMA = 4'd7,
		ST_CRC = 4'd8, ST_TOO_LONG = 4'd9
	} status_t;

	typedef enum logic [2:0] {
		SUB_LBRACE = 3'd0, SUB_ATTR = 3'd1, SUB_SPACE = 3'd2,
		SUB_SINGLE = 3'd3, SUB_EAST = 3'd4, SUB_NORTH = 3'd5
	} sub_t;

	// byte class made by the front part
	typedef enum logic [1:0] {
		CLS_NOISE = 2'd0, CLS_START = 2'd1, CLS_END = 2'd2, CLS_BODY = 2'd3
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [1:0] kind;
		logic       over;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [1:0]  msg_kind;
		logic [30:0] number_value;
		logic [30:0] speed;
		logic [30:0] angle;
		logic [30:0] bearing;
		logic [30:0] pos_east;
		logic [30:0] pos_north;
		logic [7:0]  crc_value;
	} res_t;

	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
		end
		return c;
	endfunction

	function automatic logic [2:0] group_count(input logic [1:0] kind);
		unique case (kind)
			2'd0: return 3'd2;
			2'd1: return 3'd3;
			default: return 3'd4;
		endcase
	endfunction

	function automatic logic [7:0] attr_letter(input logic [1:0] kind, input logic [1:0] grp);
		logic [7:0] a;
		unique case (grp)
			2'd0: a = (kind == 2'd0 || kind == 2'd2) ? "s" : "n";
			2'd1: a = (kind == 2'd0) ? "a" : "p";
			2'd2: a = "b";
			default: a = "a";
		endcase
		return a;
	endfunction

	function automatic logic [2:0] slot_base(input logic [1:0] kind, input logic [1:0] grp);
		logic [2:0] s;
		unique case (grp)
			2'd0: s = 3'd0;
			2'd1: s = 3'd1;
			2'd2: s = (kind == 2'd0) ? 3'd0 : 3'd3;
			default: s = (kind == 2'd0 || kind == 2'd1) ? 3'd0 : 3'd4;
		endcase
		return s;
	endfunction

endpackage

>>> design/amfp_front.sv
module amfp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [7:0]          data_byte,
	output logic                full,
	output logic                cmd_valid,
	output amfp_pkg::cmd_t      cmd,
	input  logic                cmd_ready
);

	logic [amfp_pkg::CntW-1:0] count_q;
	logic                      take;
	amfp_pkg::cmd_t            cmd_c;
	logic [amfp_pkg::CntW-1:0] count_inc;

	assign full = !cmd_ready;
	assign take = push && cmd_ready;
	assign count_inc = count_q + 1'b1;
	assign cmd_valid = take;
	assign cmd = cmd_c;

	// classify the byte and track the line length
	always_comb begin
		cmd_c.data = data_byte;
		cmd_c.kind = 2'd0;
		cmd_c.over = 1'b0;
		priority if (data_byte == 8'h09 || data_byte == 8'h00 || data_byte == 8'h0D) begin
			cmd_c.cls = amfp_pkg::CLS_NOISE;
		end else if (data_byte == "D" || data_byte == "G" || data_byte == "S"
				|| data_byte == "X") begin
			cmd_c.cls = amfp_pkg::CLS_START;
			cmd_c.kind = (data_byte == "D") ? 2'd0 : (data_byte == "G") ? 2'd1 :
				(data_byte == "S") ? 2'd2 : 2'd3;
		end else if (data_byte == 8'h0A) begin
			cmd_c.cls = amfp_pkg::CLS_END;
		end else begin
			cmd_c.cls = amfp_pkg::CLS_BODY;
			cmd_c.over = (count_inc >= amfp_pkg::CntW'(amfp_pkg::MaxLine));
		end
	end

	// line length counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (take) begin
			unique case (cmd_c.cls)
				amfp_pkg::CLS_START: count_q <= amfp_pkg::CntW'(1);
				amfp_pkg::CLS_BODY:  count_q <= cmd_c.over ? '0 : count_inc;
				default:             count_q <= '0;
			endcase
		end
	end

endmodule

>>> design/amfp_queue.sv
module amfp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  amfp_pkg::cmd_t in_cmd,
	output logic           in_ready,
	output logic           out_valid,
	output amfp_pkg::cmd_t out_cmd,
	input  logic           out_ready
);

	amfp_pkg::cmd_t ent_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           wr_en;
	logic           rd_en;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_cmd = ent_q[rd_q];
	assign wr_en = in_valid && in_ready;
	assign rd_en = out_valid && out_ready;

	// two entry item queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wr_q <= !wr_q;
			if (rd_en) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) ent_q[wr_q] <= in_cmd;
	end

endmodule

>>> design/amfp_back.sv
module amfp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  amfp_pkg::cmd_t cmd,
	output logic           cmd_ready,
	output logic           res_valid,
	output amfp_pkg::res_t res,
	input  logic           res_ready
);

	logic [2:0]     grp_q;
	amfp_pkg::sub_t sub_q;
	logic [1:0]     kind_q;
	logic           active_q;
	logic [7:0]     crc_q;
	logic [30:0]    field_q;
	logic [30:0]    held_q [5];
	logic [3:0]     err_q;
	logic           rv_q;
	amfp_pkg::res_t res_q;

	logic           go;
	logic           emit;
	logic           idle_n;
	amfp_pkg::res_t res_c;
	logic [2:0]     grp_n;
	amfp_pkg::sub_t sub_n;
	logic [3:0]     err_n;
	logic [7:0]     crc_n;
	logic [30:0]    field_n;
	logic           store;
	logic [2:0]     store_slot;
	logic           digit;
	logic [34:0]    acc;
	logic [30:0]    acc_sat;
	logic [7:0]     attr;
	logic [2:0]     slot;
	logic           in_groups;
	logic [3:0]     end_err;

	assign cmd_ready = !rv_q || res_ready;
	assign go = cmd_valid && cmd_ready;
	assign res_valid = rv_q;
	assign res = res_q;

	assign digit = cmd.data >= "0" && cmd.data <= "9";
	assign acc = {4'd0, field_q} * 35'd10 + {31'd0, cmd.data[3:0]};
	assign acc_sat = (acc > {4'd0, amfp_pkg::VMax}) ? amfp_pkg::VMax : acc[30:0];
	assign in_groups = grp_q < amfp_pkg::group_count(kind_q);
	assign attr = amfp_pkg::attr_letter(kind_q, grp_q[1:0]);
	assign slot = amfp_pkg::slot_base(kind_q, grp_q[1:0]);

	// body byte parse step
	always_comb begin
		grp_n = grp_q;
		sub_n = sub_q;
		err_n = err_q;
		crc_n = crc_q;
		field_n = field_q;
		store = 1'b0;
		store_slot = slot;
		if (active_q && err_q == amfp_pkg::ST_OK) begin
			if (!in_groups) begin
				if (digit) field_n = acc_sat;
				else err_n = amfp_pkg::ST_BAD_NUM;
			end else begin
				crc_n = amfp_pkg::crc_step(crc_q, cmd.data);
				unique case (sub_q)
					amfp_pkg::SUB_LBRACE: begin
						if (cmd.data == "{") sub_n = amfp_pkg::SUB_ATTR;
						else err_n = amfp_pkg::ST_BAD_BRACE;
					end
					amfp_pkg::SUB_ATTR: begin
						if (cmd.data == attr) sub_n = amfp_pkg::SUB_SPACE;
						else err_n = amfp_pkg::ST_BAD_ATTR;
					end
					amfp_pkg::SUB_SPACE: begin
						if (cmd.data == " ")
							sub_n = (attr == "p") ? amfp_pkg::SUB_EAST : amfp_pkg::SUB_SINGLE;
						else err_n = amfp_pkg::ST_NO_SPACE;
					end
					amfp_pkg::SUB_EAST: begin
						if (cmd.data == ",") begin
							store = 1'b1;
							field_n = '0;
							sub_n = amfp_pkg::SUB_NORTH;
						end else if (digit) field_n = acc_sat;
						else err_n = amfp_pkg::ST_BAD_NUM;
					end
					default: begin
						if (cmd.data == "}") begin
							store = 1'b1;
							store_slot = (sub_q == amfp_pkg::SUB_NORTH) ? slot + 3'd1 : slot;
							field_n = '0;
							grp_n = grp_q + 3'd1;
							sub_n = amfp_pkg::SUB_LBRACE;
						end else if (digit) field_n = acc_sat;
						else err_n = amfp_pkg::ST_BAD_NUM;
					end
				endcase
			end
		end
	end

	// result for noise, newline and overflow
	always_comb begin
		res_c = '0;
		emit = 1'b0;
		idle_n = 1'b0;
		end_err = err_q;
		if (end_err == amfp_pkg::ST_OK && in_groups) begin
			unique case (sub_q)
				amfp_pkg::SUB_LBRACE: end_err = amfp_pkg::ST_BAD_BRACE;
				amfp_pkg::SUB_ATTR:   end_err = amfp_pkg::ST_BAD_ATTR;
				amfp_pkg::SUB_SPACE:  end_err = amfp_pkg::ST_NO_SPACE;
				default:              end_err = amfp_pkg::ST_BAD_NUM;
			endcase
		end
		if (end_err == amfp_pkg::ST_OK && field_q != {23'd0, crc_q})
			end_err = amfp_pkg::ST_CRC;
		res_c.msg_kind = active_q ? kind_q : 2'd0;
		unique case (cmd.cls)
			amfp_pkg::CLS_NOISE: begin
				emit = 1'b1;
				idle_n = 1'b1;
				res_c.status = amfp_pkg::ST_NOISE;
			end
			amfp_pkg::CLS_END: begin
				emit = 1'b1;
				idle_n = 1'b1;
				if (!active_q) begin
					res_c.status = amfp_pkg::ST_BAD_TYPE;
				end else begin
					res_c.status = end_err;
					if (end_err == amfp_pkg::ST_CRC) res_c.crc_value = crc_q;
					if (end_err == amfp_pkg::ST_OK) begin
						res_c.crc_value = crc_q;
						if (kind_q == 2'd0) begin
							res_c.speed = held_q[0];
							res_c.angle = held_q[1];
						end else begin
							if (kind_q == 2'd2) res_c.speed = held_q[0];
							else res_c.number_value = held_q[0];
							res_c.pos_east = held_q[1];
							res_c.pos_north = held_q[2];
							res_c.bearing = held_q[3];
							if (kind_q != 2'd1) res_c.angle = held_q[4];
						end
					end
				end
			end
			amfp_pkg::CLS_BODY: begin
				if (cmd.over) begin
					emit = 1'b1;
					idle_n = 1'b1;
					res_c.status = amfp_pkg::ST_TOO_LONG;
				end
			end
			default: ;
		endcase
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
			sub_q <= amfp_pkg::SUB_LBRACE;
			kind_q <= '0;
			active_q <= 1'b0;
			crc_q <= '0;
			field_q <= '0;
			err_q <= '0;
			rv_q <= 1'b0;
			res_q <= '0;
			for (int i = 0; i < 5; i++) held_q[i] <= '0;
		end else begin
			// output register: a new result wins over the pop of the old one
			if (go && emit) rv_q <= 1'b1;
			else if (res_ready) rv_q <= 1'b0;
			if (go) begin
				if (emit) res_q <= res_c;
				if (idle_n || cmd.cls == amfp_pkg::CLS_START) begin
					grp_q <= '0;
					sub_q <= amfp_pkg::SUB_LBRACE;
					field_q <= '0;
					err_q <= '0;
					for (int i = 0; i < 5; i++) held_q[i] <= '0;
					active_q <= (cmd.cls == amfp_pkg::CLS_START);
					kind_q <= (cmd.cls == amfp_pkg::CLS_START) ? cmd.kind : 2'd0;
					crc_q <= (cmd.cls == amfp_pkg::CLS_START) ?
						amfp_pkg::crc_step(8'd0, cmd.data) : 8'd0;
				end else begin
					grp_q <= grp_n;
					sub_q <= sub_n;
					err_q <= err_n;
					crc_q <= crc_n;
					field_q <= field_n;
					if (store && store_slot < 3'd5) held_q[store_slot] <= field_q;
				end
			end
		end
	end

endmodule

>>> design/ascii_message_frame_parser.sv
// ascii_message_frame_parser: checks ASCII frames one byte per item.
// Input channel: push/full with data_byte; an item is taken when push is
// high and full is low. Results: empty/pop; the oldest result sits on the
// result ports while empty is low and leaves when pop is high.
// Each byte gives zero or one result; a newline, noise or overflow byte
// passes the queue, and its result is registered in the output register.
// Throughput is one byte per cycle while full is low: the front classifier
// counts line length, a two-entry queue feeds the back parser, which does
// one CRC step and one multiply by ten per byte and holds its result in one
// output register. When the receiver stalls, the output register holds, the
// queue fills and full rises; no item is lost. Reset clears all frame state
// and leaves the block idle with no frame open and both channels empty.
module ascii_message_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [7:0]  data_byte,
	output logic        full,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  status,
	output logic [1:0]  msg_kind,
	output logic [30:0] number_value,
	output logic [30:0] speed,
	output logic [30:0] angle,
	output logic [30:0] bearing,
	output logic [30:0] pos_east,
	output logic [30:0] pos_north,
	output logic [7:0]  crc_value
);

	logic           f_valid;
	amfp_pkg::cmd_t f_cmd;
	logic           f_ready;
	logic           b_valid;
	amfp_pkg::cmd_t b_cmd;
	logic           b_ready;
	logic           r_valid;
	amfp_pkg::res_t r;

	amfp_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .data_byte(data_byte), .full(full),
		.cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
	);

	amfp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(f_valid), .in_cmd(f_cmd),
		.in_ready(f_ready), .out_valid(b_valid), .out_cmd(b_cmd), .out_ready(b_ready)
	);

	amfp_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(b_valid), .cmd(b_cmd),
		.cmd_ready(b_ready), .res_valid(r_valid), .res(r), .res_ready(pop)
	);

	// result ports
	assign empty = !r_valid;
	assign status = r.status;
	assign msg_kind = r.msg_kind;
	assign number_value = r.number_value;
	assign speed = r.speed;
	assign angle = r.angle;
	assign bearing = r.bearing;
	assign pos_east = r.pos_east;
	assign pos_north = r.pos_north;
	assign crc_value = r.crc_value;

endmodule

>>> verif/tb_ascii_message_frame_parser.sv
`timescale 1ns / 100ps

module tb_ascii_message_frame_parser;

	localparam int MAX_LINE_LEN = 64;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [30:0] SAT_MAX = 31'h7FFFFFFF;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic [7:0]  data_byte;
	logic        full;
	logic        empty;
	logic        pop;
	logic [3:0]  status;
	logic [1:0]  msg_kind;
	logic [30:0] number_value;
	logic [30:0] speed;
	logic [30:0] angle;
	logic [30:0] bearing;
	logic [30:0] pos_east;
	logic [30:0] pos_north;
	logic [7:0]  crc_value;

	ascii_message_frame_parser i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .data_byte(data_byte), .full(full),
		.empty(empty), .pop(pop), .status(status), .msg_kind(msg_kind),
		.number_value(number_value), .speed(speed), .angle(angle), .bearing(bearing),
		.pos_east(pos_east), .pos_north(pos_north), .crc_value(crc_value)
	);

	// parser model state
	logic [4:0]  pm_phase;
	logic [1:0]  pm_kind;
	logic        pm_active;
	int          pm_count;
	logic [7:0]  pm_crc;
	logic [30:0] pm_acc;
	logic [30:0] pm_held [5];
	logic [3:0]  pm_err;

	logic [7:0]     byte_q [$];
	amfp_pkg::res_t frame_q [$];

	int cycles, mismatches, bytes_sent, frames_seen, kind_ok [4];
	int send_idle_pct, recv_stall_pct;

	function automatic logic [7:0] crc8(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++)
			c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
		return c;
	endfunction

	function automatic int groups_of(input logic [1:0] k);
		return (k == 2'd0) ? 2 : (k == 2'd1) ? 3 : 4;
	endfunction

	function automatic logic [7:0] attr_of(input logic [1:0] k, input int g);
		case (g)
			0: return (k == 2'd0 || k == 2'd2) ? "s" : "n";
			1: return (k == 2'd0) ? "a" : "p";
			2: return "b";
			default: return "a";
		endcase
	endfunction

	function automatic int slot_of(input logic [1:0] k, input int g);
		case (g)
			0: return 0;
			1: return 1;
			2: return (k == 2'd0) ? 0 : 3;
			default: return (k == 2'd0 || k == 2'd1) ? 0 : 4;
		endcase
	endfunction

	task automatic parser_clear();
		pm_phase = 0;
		pm_kind = 0;
		pm_active = 0;
		pm_count = 0;
		pm_crc = 0;
		pm_acc = 0;
		for (int i = 0; i < 5; i++) pm_held[i] = 0;
		pm_err = 0;
	endtask

	function automatic amfp_pkg::res_t error_frame(input logic [3:0] st);
		amfp_pkg::res_t r;
		r = '0;
		r.status = st;
		r.msg_kind = pm_active ? pm_kind : 2'd0;
		return r;
	endfunction

	task automatic add_digit(input logic [7:0] b);
		logic [63:0] v;
		v = 64'(pm_acc) * 10 + 64'(b - "0");
		pm_acc = (v > 64'(SAT_MAX)) ? SAT_MAX : v[30:0];
	endtask

	// body byte while the frame is still clean
	task automatic parse_body(input logic [7:0] b);
		int g, s, sl;
		logic [7:0] at;
		bit dig;
		g = pm_phase / 6;
		s = pm_phase % 6;
		dig = (b >= "0" && b <= "9");
		if (g >= groups_of(pm_kind)) begin
			if (dig) add_digit(b);
			else pm_err = amfp_pkg::ST_BAD_NUM;
			return;
		end
		pm_crc = crc8(pm_crc, b);
		at = attr_of(pm_kind, g);
		sl = slot_of(pm_kind, g);
		if (s == amfp_pkg::SUB_LBRACE) begin
			if (b == "{") s = amfp_pkg::SUB_ATTR; else pm_err = amfp_pkg::ST_BAD_BRACE;
		end else if (s == amfp_pkg::SUB_ATTR) begin
			if (b == at) s = amfp_pkg::SUB_SPACE; else pm_err = amfp_pkg::ST_BAD_ATTR;
		end else if (s == amfp_pkg::SUB_SPACE) begin
			if (b == " ") s = (at == "p") ? amfp_pkg::SUB_EAST : amfp_pkg::SUB_SINGLE;
			else pm_err = amfp_pkg::ST_NO_SPACE;
		end else if (s == amfp_pkg::SUB_EAST) begin
			if (b == ",") begin
				pm_held[sl] = pm_acc;
				pm_acc = 0;
				s = amfp_pkg::SUB_NORTH;
			end else if (dig) add_digit(b);
			else pm_err = amfp_pkg::ST_BAD_NUM;
		end else begin
			if (b == "}") begin
				pm_held[(s == amfp_pkg::SUB_NORTH) ? sl + 1 : sl] = pm_acc;
				pm_acc = 0;
				g++;
				s = amfp_pkg::SUB_LBRACE;
			end else if (dig) add_digit(b);
			else pm_err = amfp_pkg::ST_BAD_NUM;
		end
		pm_phase = 5'(g * 6 + s);
	endtask

	// one accepted byte: update model, maybe queue one expected frame result
	task automatic predict_byte(input logic [7:0] b);
		amfp_pkg::res_t r;
		int g, s;
		logic [3:0] e;
		if (b == 8'h09 || b == 8'h00 || b == 8'h0D) begin
			frame_q.push_back(error_frame(amfp_pkg::ST_NOISE));
			parser_clear();
		end else if (b == "D" || b == "G" || b == "S" || b == "X") begin
			parser_clear();
			pm_kind = (b == "D") ? 2'd0 : (b == "G") ? 2'd1 : (b == "S") ? 2'd2 : 2'd3;
			pm_active = 1;
			pm_count = 1;
			pm_crc = crc8(8'h00, b);
		end else if (b == 8'h0A) begin
			if (!pm_active) begin
				frame_q.push_back(error_frame(amfp_pkg::ST_BAD_TYPE));
			end else begin
				g = pm_phase / 6;
				s = pm_phase % 6;
				e = pm_err;
				if (e == 0 && g < groups_of(pm_kind))
					e = (s == amfp_pkg::SUB_LBRACE) ? amfp_pkg::ST_BAD_BRACE :
						(s == amfp_pkg::SUB_ATTR) ? amfp_pkg::ST_BAD_ATTR :
						(s == amfp_pkg::SUB_SPACE) ? amfp_pkg::ST_NO_SPACE :
						amfp_pkg::ST_BAD_NUM;
				if (e == 0 && pm_acc != 31'(pm_crc)) e = amfp_pkg::ST_CRC;
				r = error_frame(e);
				if (e == amfp_pkg::ST_CRC) r.crc_value = pm_crc;
				if (e == amfp_pkg::ST_OK) begin
					r.crc_value = pm_crc;
					if (pm_kind == 2'd0) begin
						r.speed = pm_held[0];
						r.angle = pm_held[1];
					end else begin
						if (pm_kind == 2'd2) r.speed = pm_held[0];
						else r.number_value = pm_held[0];
						r.pos_east = pm_held[1];
						r.pos_north = pm_held[2];
						r.bearing = pm_held[3];
						if (pm_kind != 2'd1) r.angle = pm_held[4];
					end
				end
				frame_q.push_back(r);
			end
			parser_clear();
		end else begin
			pm_count++;
			if (pm_count >= MAX_LINE_LEN) begin
				frame_q.push_back(error_frame(amfp_pkg::ST_TOO_LONG));
				parser_clear();
			end else if (pm_active && pm_err == 0) begin
				parse_body(b);
			end
		end
	endtask

	// build a frame, maybe corrupted
	function automatic logic [30:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return SAT_MAX;
			2: return 31'($urandom_range(0, 9));
			3: return 31'($urandom);
			default: return 31'($urandom_range(0, 99999));
		endcase
	endfunction

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
	endtask

	task automatic queue_frame(input int k, input int corrupt);
		string s, t;
		logic [7:0] c;
		int p;
		byte letters [4];
		letters = '{"D", "G", "S", "X"};
		s = $sformatf("%c", letters[k]);
		for (int g = 0; g < groups_of(2'(k)); g++) begin
			if (attr_of(2'(k), g) == "p")
				t = $sformatf("{p %0d,%0d}", rand_value(), rand_value());
			else
				t = $sformatf("{%c %0d}", attr_of(2'(k), g), rand_value());
			if ($urandom_range(0, 9) == 0) t = $sformatf("{%c }", attr_of(2'(k), g));
			if ($urandom_range(0, 19) == 0)
				t = {t.substr(0, 2), "99999999999", t.substr(3, t.len() - 1)};
			s = {s, t};
		end
		c = 0;
		for (int i = 0; i < s.len(); i++) c = crc8(c, s[i]);
		s = {s, $sformatf("%0d", c)};
		if (corrupt == 1) begin
			p = $urandom_range(1, s.len() - 1);
			s[p] = 8'($urandom_range(32, 126));
		end else if (corrupt == 2) begin
			s = s.substr(0, $urandom_range(0, s.len() - 2));
		end else if (corrupt == 3) begin
			s = {s, "1"};
		end
		push_str(s);
		byte_q.push_back(8'h0A);
	endtask

	task automatic wait_drained();
		while (byte_q.size() != 0 || frame_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// clock and cycle limit
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("ascii_message_frame_parser: mismatch");
			$finish;
		end
	end

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 0;
		end else begin
			if (byte_q.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
				push <= 1;
				data_byte <= byte_q[0];
			end else begin
				push <= 0;
				data_byte <= 8'($urandom);
			end
			pop <= ($urandom_range(1, 100) > recv_stall_pct);
		end
	end

	// monitor: input acceptance and result check at the rising edge
	always @(posedge clk) begin
		amfp_pkg::res_t got, want;
		if (arst_n && pop && !empty) begin
			got = '{status, msg_kind, number_value, speed, angle, bearing,
				pos_east, pos_north, crc_value};
			if (frame_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				want = frame_q.pop_front();
				frames_seen++;
				if (got.status == amfp_pkg::ST_OK) kind_ok[got.msg_kind]++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected %p, got %p", frames_seen, want, got);
				end
			end
		end
		if (arst_n && push && !full) begin
			predict_byte(data_byte);
			void'(byte_q.pop_front());
			bytes_sent++;
		end
	end

	initial begin
		cycles = 0;
		mismatches = 0;
		bytes_sent = 0;
		frames_seen = 0;
		kind_ok = '{0, 0, 0, 0};
		send_idle_pct = 0;
		recv_stall_pct = 0;
		push = 0;
		pop = 0;
		data_byte = 0;
		parser_clear();
		arst_n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed items: noise, bare newline, every kind, errors, overflow
		byte_q.push_back(8'h0A);
		byte_q.push_back(8'h09);
		byte_q.push_back(8'h00);
		byte_q.push_back(8'h0D);
		for (int k = 0; k < 4; k++) queue_frame(k, 0);
		push_str("D{s 5");
		byte_q.push_back(8'h0A);
		push_str("Gx");
		byte_q.push_back(8'h0A);
		push_str("X{n 1");
		byte_q.push_back(8'h0D);
		push_str("S{s1");
		byte_q.push_back(8'h0A);
		push_str("G{n 1}{p 2;3}");
		byte_q.push_back(8'h0A);
		for (int i = 0; i < 70; i++) byte_q.push_back("z");
		push_str("D{s 1}{a 2}X");
		byte_q.push_back(8'hFF);
		byte_q.push_back(8'h80);
		byte_q.push_back(8'h0A);
		wait_drained();

		// random part over idling phases, about 350 bytes each
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 22 : 55) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 22 : 55) : 0;
			while (byte_q.size() < 350) begin
				if ($urandom_range(0, 9) < 7) begin
					queue_frame($urandom_range(0, 3),
						($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
				end else begin
					repeat ($urandom_range(1, 8)) begin
						byte_q.push_back(($urandom_range(0, 3) == 0) ? 8'h0A : 8'($urandom));
					end
				end
			end
			wait_drained();
		end
		$display("sent %0d bytes, checked %0d results; ok frames D/G/S/X: %0d %0d %0d %0d",
			bytes_sent, frames_seen, kind_ok[0], kind_ok[1], kind_ok[2], kind_ok[3]);
		$display("idling phases covered: none, sender, receiver, both; %0d mismatches",
			mismatches);
		if (mismatches == 0 && frame_q.size() == 0) begin
			$display("ascii_message_frame_parser: match");
		end else begin
			$display("ascii_message_frame_parser: mismatch");
		end
		$finish;
	end

endmodule

>>> ascii_message_frame_parser.f
design/amfp_pkg.sv
design/amfp_front.sv
design/amfp_queue.sv
design/amfp_back.sv
design/ascii_message_frame_parser.sv
verif/tb_ascii_message_frame_parser.sv
